>>> rtl/satx_pkg.sv
// shared types, constants and decode functions of the sprite tile expander
package satx_pkg;

  // attribute word bit positions
  localparam int unsigned FlashBit  = 12;
  localparam int unsigned FlipXBit  = 13;
  localparam int unsigned FlipYBit  = 14;
  localparam int unsigned HeightLsb = 9;
  localparam int unsigned ColourLsb = 9;
  localparam int unsigned PriLsb    = 14;

  // wrap limit of the horizontal position and the left cull limit
  localparam logic [8:0] XWrapLimit = 9'd320;
  localparam logic [8:0] XCullLimit = 9'd496;

  // priority codes and masks
  localparam logic [1:0] PriNone = 2'd0;
  localparam logic [1:0] PriLow  = 2'd1;
  localparam logic [1:0] PriMid  = 2'd2;
  localparam logic [1:0] PriHigh = 2'd3;

  localparam logic [7:0] MaskNone = 8'h00;
  localparam logic [7:0] MaskLow  = 8'hf0;
  localparam logic [7:0] MaskHigh = 8'hfc;

  // controller states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic drop;
    logic last;
  } dp_status_t;

  // priority code to mask, the two top codes share a mask
  function automatic logic [7:0] pri_mask(input logic [1:0] code);
    logic [7:0] mask;
    case (code) inside
      PriNone:         mask = MaskNone;
      PriLow:          mask = MaskLow;
      PriMid, PriHigh: mask = MaskHigh;
      default:         mask = MaskNone;
    endcase
    return mask;
  endfunction

  // height code to row mask (1, 2, 4 or 8 rows)
  function automatic logic [2:0] row_mask(input logic [1:0] hcode);
    logic [2:0] m;
    unique case (hcode)
      2'd0:    m = 3'd0;
      2'd1:    m = 3'd1;
      2'd2:    m = 3'd3;
      2'd3:    m = 3'd7;
      default: m = 3'd0;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/satx_if.sv
// valid/ready channel interfaces for sprite entries and tile commands

// sprite entry channel
interface satx_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] attr_y_word;
  logic [15:0] tile_word;
  logic [15:0] attr_x_word;
  logic        frame_odd;

  modport source (
    output valid, attr_y_word, tile_word, attr_x_word, frame_odd,
    input  ready
  );
  modport sink (
    input  valid, attr_y_word, tile_word, attr_x_word, frame_odd,
    output ready
  );
endinterface

// tile command channel
interface satx_out_if;
  logic              valid;
  logic              ready;
  logic [15:0]       tile_code;
  logic [4:0]        colour_bank;
  logic              mirror_x;
  logic              mirror_y;
  logic signed [9:0] screen_x;
  logic signed [9:0] screen_y;
  logic [7:0]        priority_mask;
  logic              last_tile;

  modport source (
    output valid, tile_code, colour_bank, mirror_x, mirror_y, screen_x, screen_y,
           priority_mask, last_tile,
    input  ready
  );
  modport sink (
    input  valid, tile_code, colour_bank, mirror_x, mirror_y, screen_x, screen_y,
           priority_mask, last_tile,
    output ready
  );
endinterface

>>> rtl/satx_ctrl.sv
// controller: takes sprite entries and sequences the tile command beats
module satx_ctrl
  import satx_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output logic       out_valid,
  input  logic       out_ready,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and handshakes
  always_comb begin
    logic out_beat;
    logic take;
    out_beat  = 1'b0;
    take      = 1'b0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        out_beat  = out_ready;
        // a new entry may follow the last beat directly
        in_ready  = out_ready && status.last;
        if (out_beat) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    take = in_valid && in_ready;
    if (take) begin
      cmd.load  = 1'b1;
      state_nxt = status.drop ? ST_IDLE : ST_EMIT;
    end
  end

endmodule

>>> rtl/satx_dp.sv
// datapath: decodes a sprite entry and forms one tile command per row
module satx_dp
  import satx_pkg::*;
(
  input  logic              clk,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic [15:0]       attr_y_word,
  input  logic [15:0]       tile_word,
  input  logic [15:0]       attr_x_word,
  input  logic              frame_odd,
  output logic [15:0]       tile_code,
  output logic [4:0]        colour_bank,
  output logic              mirror_x,
  output logic              mirror_y,
  output logic signed [9:0] screen_x,
  output logic signed [9:0] screen_y,
  output logic [7:0]        priority_mask
);

  logic [15:0]       base_r;
  logic [2:0]        mask_r;
  logic [2:0]        row_r;
  logic [4:0]        colour_r;
  logic [7:0]        pri_r;
  logic              fx_r;
  logic              fy_r;
  logic signed [9:0] x_r;
  logic signed [9:0] y_r;

  logic [8:0]        x_raw;
  logic [8:0]        y_raw;
  logic [2:0]        mask_in;
  logic              x_wrap;
  logic [2:0]        code_off;
  logic [9:0]        row_dy;

  // entry decode
  always_comb begin
    x_raw   = attr_x_word[8:0];
    y_raw   = attr_y_word[8:0];
    mask_in = row_mask(attr_y_word[HeightLsb +: 2]);
    x_wrap  = (x_raw >= XWrapLimit);
    // hidden flashing sprite, or wrapped x below -16
    status.drop = (attr_y_word[FlashBit] && frame_odd) ||
                  (x_wrap && (x_raw < XCullLimit));
    status.last = (row_r == 3'd0);
  end

  // entry registers and row counter, rows run from the top index down to zero
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      base_r   <= tile_word & ~{13'd0, mask_in};
      mask_r   <= mask_in;
      row_r    <= mask_in;
      colour_r <= attr_x_word[ColourLsb +: 5];
      pri_r    <= pri_mask(attr_x_word[PriLsb +: 2]);
      fx_r     <= attr_y_word[FlipXBit];
      fy_r     <= attr_y_word[FlipYBit];
      x_r      <= {x_wrap, x_raw};
      y_r      <= {y_raw[8], y_raw};
    end else if (cmd.step) begin
      row_r    <= row_r - 3'd1;
    end
  end

  // per-row command fields; low base bits are clear so add is an or
  always_comb begin
    code_off      = fy_r ? row_r : (mask_r ^ row_r);
    row_dy        = {3'd0, row_r, 4'd0};
    tile_code     = base_r | {13'd0, code_off};
    colour_bank   = colour_r;
    mirror_x      = ~fx_r;
    mirror_y      = ~fy_r;
    screen_x      = x_r;
    screen_y      = y_r + $signed(row_dy);
    priority_mask = pri_r;
  end

endmodule

>>> rtl/sprite_attribute_tile_expander_core.sv
// top level of the sprite attribute tile expander
//
// in_chan takes one sprite list entry per beat: three attribute words and
// the frame parity. out_chan gives the tile draw commands of that entry,
// one per 16-pixel row, starting at the bottom row, with last_tile set on
// the final one. Both channels move a beat when valid and ready are high.
// An entry of height h (1, 2, 4 or 8 tiles) gives h beats, one per cycle
// while the receiver is ready, counted by the row counter in the datapath.
// The next entry is taken in the same cycle as the last beat, so entries
// follow without a gap. A flashing sprite on an odd frame, or one wrapped
// past the left edge, gives no beat. First beat appears the cycle after
// the entry is taken. When the receiver stalls, the current command holds
// and no new entry is taken. Synchronous reset returns the controller to
// idle with no beat pending; the datapath registers are not reset.
module sprite_attribute_tile_expander_core
  import satx_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  satx_in_if.sink     in_chan,
  satx_out_if.source  out_chan
);

  dp_cmd_t    cmd;
  dp_status_t status;

  satx_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .cmd       (cmd),
    .status    (status)
  );

  satx_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .status        (status),
    .attr_y_word   (in_chan.attr_y_word),
    .tile_word     (in_chan.tile_word),
    .attr_x_word   (in_chan.attr_x_word),
    .frame_odd     (in_chan.frame_odd),
    .tile_code     (out_chan.tile_code),
    .colour_bank   (out_chan.colour_bank),
    .mirror_x      (out_chan.mirror_x),
    .mirror_y      (out_chan.mirror_y),
    .screen_x      (out_chan.screen_x),
    .screen_y      (out_chan.screen_y),
    .priority_mask (out_chan.priority_mask)
  );

  // last beat of the entry
  assign out_chan.last_tile = status.last;

endmodule
